FILE: hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned POS_W  = 3;

	// Header byte positions; the last one marks payload reception
	localparam logic [POS_W-1:0] POS_TYPE_HI  = 3'd0;
	localparam logic [POS_W-1:0] POS_TYPE_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_CHECK_HI = 3'd2;
	localparam logic [POS_W-1:0] POS_CHECK_LO = 3'd3;
	localparam logic [POS_W-1:0] POS_LEN_HI   = 3'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO   = 3'd5;
	localparam logic [POS_W-1:0] POS_PAYLOAD  = 3'd6;

	localparam logic [WORD_W-1:0] HDR_BYTES  = 16'd6;
	localparam logic [WORD_W-1:0] TYPE_RESET = 16'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              carries_payload;
		logic              frame_end;
		logic              type_error;
		logic              checksum_error;
		logic              length_error;
	} frc_result_t;

endpackage

FILE: hw/rtl/frc_in_stage.sv
// ----------------------------------------------------------------------------
// frc_in_stage
// Input register for received bytes.
// ----------------------------------------------------------------------------
module frc_in_stage
	import frc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              take,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

FILE: hw/rtl/frc_core.sv
// ----------------------------------------------------------------------------
// frc_core
// Header parser, running 16-bit sum and frame-end checks for one byte.
// ----------------------------------------------------------------------------
module frc_core
	import frc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              valid_s1,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              out_ready,
	output logic              take,
	output logic              res_valid,
	output frc_result_t       res
);

	logic [WORD_W-1:0] exp_type_q;
	logic [POS_W-1:0]  hdr_pos_q,    hdr_pos_n;
	logic [WORD_W-1:0] frame_type_q, frame_type_n;
	logic [WORD_W-1:0] rx_check_q,   rx_check_n;
	logic [WORD_W-1:0] remain_q,     remain_n;
	logic [WORD_W-1:0] sum_q,        sum_n;
	logic [BYTE_W-1:0] pend_q,       pend_n;
	logic              odd_q,        odd_n;

	logic [WORD_W-1:0] len;
	logic [WORD_W-1:0] hdr_sum;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] pay_sum;
	logic [WORD_W-1:0] remain_dec;
	logic              type_mis;

	assign take = valid_s1 && (!res_valid || out_ready);

	always_comb begin
		len        = {remain_q[WORD_W-1:BYTE_W], byte_s1};
		hdr_sum    = exp_type_q + len;
		word       = odd_q ? {pend_q, byte_s1} : {byte_s1, {BYTE_W{1'b0}}};
		pay_sum    = sum_q + word;
		remain_dec = remain_q - 16'd1;
		type_mis   = frame_type_q != exp_type_q;

		hdr_pos_n    = hdr_pos_q;
		frame_type_n = frame_type_q;
		rx_check_n   = rx_check_q;
		remain_n     = remain_q;
		sum_n        = sum_q;
		pend_n       = pend_q;
		odd_n        = odd_q;
		res_valid    = 1'b0;
		res          = '0;

		if (valid_s1) begin
			unique case (hdr_pos_q)
				POS_TYPE_HI: begin
					frame_type_n = {byte_s1, {BYTE_W{1'b0}}};
					hdr_pos_n    = POS_TYPE_LO;
				end
				POS_TYPE_LO: begin
					frame_type_n = {frame_type_q[WORD_W-1:BYTE_W], byte_s1};
					hdr_pos_n    = POS_CHECK_HI;
				end
				POS_CHECK_HI: begin
					rx_check_n = {byte_s1, {BYTE_W{1'b0}}};
					hdr_pos_n  = POS_CHECK_LO;
				end
				POS_CHECK_LO: begin
					rx_check_n = {rx_check_q[WORD_W-1:BYTE_W], byte_s1};
					hdr_pos_n  = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					// hold the length high byte until the low byte arrives
					remain_n  = {byte_s1, {BYTE_W{1'b0}}};
					hdr_pos_n = POS_LEN_LO;
				end
				POS_LEN_LO: begin
					sum_n  = hdr_sum;
					pend_n = '0;
					odd_n  = 1'b0;
					if (len < HDR_BYTES) begin
						remain_n           = '0;
						hdr_pos_n          = POS_TYPE_HI;
						res_valid          = 1'b1;
						res.frame_end      = 1'b1;
						res.type_error     = type_mis;
						res.length_error   = 1'b1;
					end else if (len == HDR_BYTES) begin
						remain_n           = '0;
						hdr_pos_n          = POS_TYPE_HI;
						res_valid          = 1'b1;
						res.frame_end      = 1'b1;
						res.type_error     = type_mis;
						res.checksum_error = (~hdr_sum) != rx_check_q;
					end else begin
						remain_n  = len - HDR_BYTES;
						hdr_pos_n = POS_PAYLOAD;
					end
				end
				POS_PAYLOAD: begin
					remain_n            = remain_dec;
					res_valid           = 1'b1;
					res.payload_byte    = byte_s1;
					res.carries_payload = 1'b1;
					if (remain_dec == '0) begin
						// fold in the last word, zero-padded when the tail is odd
						sum_n              = pay_sum;
						pend_n             = '0;
						odd_n              = 1'b0;
						hdr_pos_n          = POS_TYPE_HI;
						res.frame_end      = 1'b1;
						res.type_error     = type_mis;
						res.checksum_error = (~pay_sum) != rx_check_q;
					end else if (odd_q) begin
						sum_n  = pay_sum;
						pend_n = '0;
						odd_n  = 1'b0;
					end else begin
						pend_n = byte_s1;
						odd_n  = 1'b1;
					end
				end
				default: begin
					hdr_pos_n = POS_TYPE_HI;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_type_q <= TYPE_RESET;
		end else if (cfg_valid) begin
			exp_type_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= POS_TYPE_HI;
			frame_type_q <= '0;
			rx_check_q   <= '0;
			remain_q     <= '0;
			sum_q        <= '0;
			pend_q       <= '0;
			odd_q        <= 1'b0;
		end else if (take) begin
			hdr_pos_q    <= hdr_pos_n;
			frame_type_q <= frame_type_n;
			rx_check_q   <= rx_check_n;
			remain_q     <= remain_n;
			sum_q        <= sum_n;
			pend_q       <= pend_n;
			odd_q        <= odd_n;
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_pos_q == POS_PAYLOAD) |-> (remain_q != '0))
		else $error("payload phase with zero bytes left");

	a_odd_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		odd_q |-> (hdr_pos_q == POS_PAYLOAD))
		else $error("pending high byte outside payload");

	a_len_err_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.length_error) |->
			(res.frame_end && !res.checksum_error && !res.carries_payload))
		else $error("length error result with inconsistent flags");

	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (hdr_pos_q == POS_PAYLOAD)) |-> res_valid)
		else $error("payload byte without a result");

	a_end_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_valid && res.frame_end) |=> (hdr_pos_q == POS_TYPE_HI))
		else $error("frame end did not restart the header");

endmodule

FILE: hw/rtl/frc_out_reg.sv
// ----------------------------------------------------------------------------
// frc_out_reg
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module frc_out_reg
	import frc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  frc_result_t res,
	output logic        can_load,
	output logic        valid_s2,
	output frc_result_t result_s2,
	input  logic        out_ready
);

	assign can_load = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= res;
		end
	end

endmodule

FILE: hw/rtl/frame_receiver_with_checksum_check_unit.sv
// A byte accepted into the input register is parsed combinationally and its result,
// if any, is loaded into the result register that drives the output stream.
// Throughput: one byte per cycle, set by the single parse stage between the
// input register and the result register; a stalled result holds the input.
// Reset clears the header position, running sum and the valid flags of both stream
// registers; expected_type returns to 7.
// ----------------------------------------------------------------------------
// frame_receiver_with_checksum_check_unit
// Byte-stream frame receiver with header parsing and inverted-sum check.
// ----------------------------------------------------------------------------
module frame_receiver_with_checksum_check_unit
	import frc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,       // expected_type
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // payload_byte, type_error, checksum_error,
	                                    // length_error, zero fill
	output logic        m_axis_tuser,   // carries_payload
	output logic        m_axis_tlast    // frame_end
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              take;
	logic              res_valid;
	frc_result_t       res;
	logic              can_load;
	frc_result_t       result_s2;

	assign cfg_ready = 1'b1;

	frc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	frc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.out_ready (can_load),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	frc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && res_valid),
		.res       (res),
		.can_load  (can_load),
		.valid_s2  (m_axis_tvalid),
		.result_s2 (result_s2),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {5'b00000, result_s2.length_error, result_s2.checksum_error,
		result_s2.type_error, result_s2.payload_byte};
	assign m_axis_tuser = result_s2.carries_payload;
	assign m_axis_tlast = result_s2.frame_end;

endmodule

FILE: test/frc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_checker
// Follows the byte, result and register streams of the frame receiver,
// predicts the result, if any, of every accepted byte and compares it field by field
// with the result the block emits.
// ----------------------------------------------------------------------------
module frc_checker
	import frc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,       // expected_type
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // payload_byte, type_error, checksum_error,
	                                    // length_error, zero fill
	input  logic        m_axis_tuser,   // carries_payload
	input  logic        m_axis_tlast,   // frame_end
	output int          fail_count,
	output int          pending_results
);

	logic [WORD_W-1:0] accepted_type;
	logic [WORD_W-1:0] frame_type;
	logic [WORD_W-1:0] header_check;
	logic [WORD_W-1:0] bytes_left;
	logic [WORD_W-1:0] word_sum;
	logic [POS_W-1:0]  hdr_pos;
	logic [BYTE_W-1:0] high_byte;
	logic              low_next;
	frc_result_t       frame_results[$];
	int                mismatches = 0;
	int                queued = 0;

	assign fail_count      = mismatches;
	assign pending_results = queued;

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		frc_result_t       r;
		logic [WORD_W-1:0] len;
		r = '0;
		if (hdr_pos != POS_PAYLOAD) begin
			case (hdr_pos)
				POS_TYPE_HI: begin
					frame_type = {b, 8'h00};
					hdr_pos    = POS_TYPE_LO;
				end
				POS_TYPE_LO: begin
					frame_type[7:0] = b;
					hdr_pos         = POS_CHECK_HI;
				end
				POS_CHECK_HI: begin
					header_check = {b, 8'h00};
					hdr_pos      = POS_CHECK_LO;
				end
				POS_CHECK_LO: begin
					header_check[7:0] = b;
					hdr_pos           = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					bytes_left = {b, 8'h00};
					hdr_pos    = POS_LEN_LO;
				end
				default: begin
					len       = bytes_left | b;
					word_sum  = accepted_type + len;
					high_byte = '0;
					low_next  = 1'b0;
					if (len <= HDR_BYTES) begin
						// no payload: the frame closes on this byte
						bytes_left   = '0;
						hdr_pos      = POS_TYPE_HI;
						r.frame_end  = 1'b1;
						r.type_error = frame_type != accepted_type;
						if (len < HDR_BYTES)
							r.length_error = 1'b1;
						else
							r.checksum_error = ~word_sum != header_check;
						frame_results.push_back(r);
					end else begin
						bytes_left = len - HDR_BYTES;
						hdr_pos    = POS_PAYLOAD;
					end
				end
			endcase
		end else begin
			if (!low_next) begin
				high_byte = b;
				low_next  = 1'b1;
			end else begin
				word_sum  = word_sum + {high_byte, b};
				high_byte = '0;
				low_next  = 1'b0;
			end
			bytes_left        = bytes_left - 1'b1;
			r.payload_byte    = b;
			r.carries_payload = 1'b1;
			if (bytes_left == 0) begin
				// pad an odd tail with a zero low byte
				if (low_next) begin
					word_sum  = word_sum + {high_byte, 8'h00};
					high_byte = '0;
					low_next  = 1'b0;
				end
				hdr_pos          = POS_TYPE_HI;
				r.frame_end      = 1'b1;
				r.type_error     = frame_type != accepted_type;
				r.checksum_error = ~word_sum != header_check;
			end
			frame_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frc_result_t seen;
		frc_result_t want;
		if (!arst_n) begin
			accepted_type = TYPE_RESET;
			frame_type    = '0;
			header_check  = '0;
			bytes_left    = '0;
			word_sum      = '0;
			hdr_pos       = POS_TYPE_HI;
			high_byte     = '0;
			low_next      = 1'b0;
			frame_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.payload_byte    = m_axis_tdata[7:0];
				seen.type_error      = m_axis_tdata[8];
				seen.checksum_error  = m_axis_tdata[9];
				seen.length_error    = m_axis_tdata[10];
				seen.carries_payload = m_axis_tuser;
				seen.frame_end       = m_axis_tlast;
				if (frame_results.size() == 0) begin
					$error("result with no request pending: payload_byte %0h, frame_end %0b",
						seen.payload_byte, seen.frame_end);
					mismatches++;
				end else begin
					want = frame_results.pop_front();
					check_field("payload_byte", want.payload_byte, seen.payload_byte);
					check_field("carries_payload", want.carries_payload, seen.carries_payload);
					check_field("frame_end", want.frame_end, seen.frame_end);
					check_field("type_error", want.type_error, seen.type_error);
					check_field("checksum_error", want.checksum_error, seen.checksum_error);
					check_field("length_error", want.length_error, seen.length_error);
				end
			end
			if (cfg_valid && cfg_ready)
				accepted_type = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				parse_rx_byte(s_axis_tdata);
		end
		queued = frame_results.size();
	end

endmodule

FILE: test/tb_frame_receiver_with_checksum_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_receiver_with_checksum_check_unit
// Feeds framed byte streams (good frames, empty and short ones, wrong types
// and bad check values) under several expected types, with bursty input and
// a stalling result side; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_frame_receiver_with_checksum_check_unit;
	import frc_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_TARGET = 1450;
	localparam int PHASE_BYTES = 280;

	typedef enum int {DRAIN_OPEN, DRAIN_RANDOM, DRAIN_CADENCE, DRAIN_HOLD} drain_mode_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int          fail_count;
	int          pending_results;
	int          bytes_sent;
	int          burst_left;
	int          cycle_count = 0;
	logic [15:0] cfg_type;

	frame_receiver_with_checksum_check_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	frc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("frame_receiver_with_checksum_check_unit regression: fail");
			$finish;
		end
	end

	// Send one byte; the sender works in bursts with random gaps between them.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Write expected_type once every pending result has drained.
	task automatic set_type(input logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_type = value;
	endtask

	// Build and send one frame. A split position of zero or more rewrites the
	// register before that header byte; the check value follows the new type.
	task automatic send_frame(input logic [15:0] ftype, input logic [15:0] flen,
			input bit corrupt, input int split_at, input logic [15:0] split_type);
		logic [7:0]  body[$];
		logic [7:0]  header[6];
		logic [15:0] sum;
		logic [15:0] check;
		int          i;
		sum = ((split_at >= 0) ? split_type : cfg_type) + flen;
		for (i = 6; i < flen; i++) begin
			case ($urandom_range(0, 7))
				0: body.push_back(8'h00);
				1: body.push_back(8'hFF);
				default: body.push_back(8'($urandom));
			endcase
		end
		for (i = 0; i < body.size(); i += 2)
			sum += {body[i], (i + 1 < body.size()) ? body[i + 1] : 8'h00};
		check = ~sum;
		if (corrupt)
			check ^= 16'($urandom_range(1, 65535));
		header = '{ftype[15:8], ftype[7:0], check[15:8], check[7:0], flen[15:8], flen[7:0]};
		for (i = 0; i < 6; i++) begin
			if (i == split_at)
				set_type(split_type);
			send_byte(header[i]);
		end
		for (i = 0; i < body.size(); i++)
			send_byte(body[i]);
	endtask

	initial begin : result_drain
		drain_mode_e mode;
		int          span;
		int          seg;
		int          tick;
		m_axis_tready = 1'b0;
		seg  = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			if (seg == 6) begin
				// hold off long enough for the input side to back up
				mode = DRAIN_HOLD;
				span = 400;
			end else begin
				mode = drain_mode_e'($urandom_range(0, 2));
				span = $urandom_range(5, 80);
			end
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					DRAIN_OPEN:    m_axis_tready <= 1'b1;
					DRAIN_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
					DRAIN_CADENCE: m_axis_tready <= (tick % 5) != 0;
					default:       m_axis_tready <= 1'b0;
				endcase
			end
			seg++;
		end
	end

	initial begin : stimulus
		int          kind;
		int          phase;
		logic [15:0] flen;
		logic [15:0] ftype;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_type      = TYPE_RESET;
		bytes_sent    = 0;
		burst_left    = 0;
		phase         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_frame(TYPE_RESET, HDR_BYTES, 1'b0, -1, 16'h0000);
		send_frame(16'h1234, 16'h0000, 1'b0, -1, 16'h0000);
		send_frame(TYPE_RESET, 16'd5, 1'b1, -1, 16'h0000);
		send_frame(TYPE_RESET, 16'd9, 1'b1, -1, 16'h0000);
		send_frame(16'hFFFF, 16'd7, 1'b0, 3, 16'hFFFF);

		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= (phase + 1) * PHASE_BYTES) begin
				phase++;
				case (phase)
					1: set_type(16'h0000);
					2: set_type(16'h8000);
					3: set_type(16'hFFFF);
					default: set_type(16'($urandom));
				endcase
			end
			kind = $urandom_range(0, 99);
			if (kind < 8)
				flen = 16'($urandom_range(0, 5));
			else if (kind < 13)
				flen = HDR_BYTES;
			else if (kind < 18)
				flen = 16'($urandom_range(100, 300));
			else
				flen = 16'($urandom_range(7, 40));
			ftype = ($urandom_range(0, 6) == 0) ? 16'($urandom) : cfg_type;
			send_frame(ftype, flen, $urandom_range(0, 6) == 0,
				($urandom_range(0, 30) == 0) ? int'($urandom_range(1, 5)) : -1,
				16'($urandom));
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("frame_receiver_with_checksum_check_unit regression: pass");
		else
			$display("frame_receiver_with_checksum_check_unit regression: fail");
		$finish;
	end

endmodule
